/* hdl/tcw_pkg.sv */
// Shared constants for the text console character writer.
package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam logic [7:0] BLANK_CODE = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0A;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int TAB_STOP = 8;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

endpackage

/* hdl/tcw_cursor.sv */
// Cursor step unit: next column and row for one put-mode byte.
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS,
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS)
) (
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  input  logic [7:0]    code_i,
  output logic [CW-1:0] col_o,
  output logic [RW-1:0] row_o,
  output logic          print_o,
  output logic          scroll_o
);

  logic [CW:0] col_ext;
  logic [CW:0] col_new;
  logic        row_inc;
  logic [RW:0] row_sum;

  assign col_ext = {1'b0, col_i};

  always_comb begin
    col_new = col_ext;
    row_inc = 1'b0;
    print_o = 1'b0;
    case (code_i)
      CH_LF: begin
        col_new = '0;
        row_inc = 1'b1;
      end
      CH_CR: begin
        col_new = '0;
      end
      CH_BS: begin
        // hold at column 0, no reverse wrap
        if (col_ext != '0) col_new = col_ext - (CW+1)'(1);
      end
      CH_TAB: begin
        col_new = (col_ext + (CW+1)'(TAB_STOP)) & ~((CW+1)'(TAB_STOP - 1));
      end
      default: begin
        col_new = col_ext + (CW+1)'(1);
        print_o = 1'b1;
      end
    endcase

    // wrap past the last column
    if (32'(col_new) >= COLUMNS) begin
      col_new = '0;
      row_inc = 1'b1;
    end

    row_sum = {1'b0, row_i} + (RW+1)'(row_inc);
    col_o   = col_new[CW-1:0];
    if (32'(row_sum) >= ROWS) begin
      row_o    = RW'(ROWS - 1);
      scroll_o = 1'b1;
    end else begin
      row_o    = row_sum[RW-1:0];
      scroll_o = 1'b0;
    end
  end

endmodule

/* hdl/text_console_char_writer.sv */
// Text console character writer: cell store, cursor and command sequencer.
//
// Takes one command at a time (put char, clear, read cell) and answers each with one
// result beat on out_valid; busy is high from acceptance until the cycle of that beat,
// and the receiver cannot stall. A put passes through S_PUT and S_OFS, a cell read
// through S_RD1, S_RD2 and S_OFS. The cell store is a single-port-write, single-port-read
// memory of COLUMNS*ROWS cells, and every bulk operation walks it one cell a cycle: a
// clear blanks every cell, and a put that scrolls adds the row copy and bottom-row fill.
// After reset the block sweeps the store to blanks with busy high; cfg writes are taken
// at any time.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_offset,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic        out_scrolled,
  output logic [15:0] out_read_cell
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SCR_CNT = CELLS - COLUMNS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PUT, S_SCR, S_FILL, S_CLR, S_RD1, S_RD2, S_OFS
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [ADDR_W-1:0] off_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              pend_r;
  logic [7:0]        attr_r;
  logic [7:0]        code_r;
  logic [10:0]       idx_r;
  logic              idx_ok_r;
  logic              scr_r;
  logic [15:0]       rd_r;
  logic              out_valid_r;

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic              cur_print;
  logic              cur_scroll;
  logic [ADDR_W-1:0] off_calc;
  logic              cnt_last;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col_i    (col_r),
    .row_i    (row_r),
    .code_i   (code_r),
    .col_o    (cur_col),
    .row_o    (cur_row),
    .print_o  (cur_print),
    .scroll_o (cur_scroll)
  );

  assign off_calc  = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);
  assign cnt_last  = (cnt_r == ADDR_W'(CELLS - 1));
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = {attr_r, BLANK_CODE};
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(idx_r);
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, BLANK_CODE};
      end
      S_CLR, S_FILL: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = cur_print;
        mem_waddr = off_r;
        mem_wdata = {attr_r, code_r};
      end
      S_SCR: begin
        // copy one row up: read cell cnt+COLUMNS, write it to cnt-1 in the next cycle
        mem_we    = pend_r;
        mem_waddr = cnt_r - ADDR_W'(1);
        mem_wdata = mem_rdata_r;
        mem_re    = (cnt_r < ADDR_W'(SCR_CNT));
        mem_raddr = cnt_r + ADDR_W'(COLUMNS);
      end
      S_RD1: begin
        mem_re = idx_ok_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      off_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            code_r   <= in_char_code;
            idx_r    <= in_cell_index;
            idx_ok_r <= (32'(in_cell_index) < CELLS);
            scr_r    <= 1'b0;
            rd_r     <= '0;
            case (in_mode)
              MODE_PUT:   state_r <= S_PUT;
              MODE_CLEAR: begin
                col_r   <= '0;
                row_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_CLR;
              end
              MODE_READ:  state_r <= S_RD1;
              default:    state_r <= S_OFS;
            endcase
          end
        end
        S_PUT: begin
          col_r <= cur_col;
          row_r <= cur_row;
          scr_r <= cur_scroll;
          if (cur_scroll) begin
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SCR;
          end else begin
            state_r <= S_OFS;
          end
        end
        S_SCR: begin
          pend_r <= (cnt_r < ADDR_W'(SCR_CNT));
          if (cnt_r == ADDR_W'(SCR_CNT)) begin
            // last pending copy lands this cycle; blank the bottom row next
            state_r <= S_FILL;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        S_FILL, S_CLR: begin
          if (cnt_last) begin
            state_r <= S_OFS;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          rd_r    <= idx_ok_r ? mem_rdata_r : 16'h0000;
          state_r <= S_OFS;
        end
        S_OFS: begin
          off_r             <= off_calc;
          out_cursor_offset <= 11'(off_calc);
          out_cursor_col    <= 7'(col_r);
          out_cursor_row    <= 5'(row_r);
          out_scrolled      <= scr_r;
          out_read_cell     <= rd_r;
          out_valid_r       <= 1'b1;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tcw_checker.sv */
// Port-level checks for the text console character writer, bound to the top level.
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [4:0]  out_cursor_row,
  input logic        out_scrolled
);

  // an accepted command always holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // one result beat per command, never two in a row
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result beats");

  // a result beat ends the busy period
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result beat outside end of command");

  // scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (out_cursor_row == 5'(ROWS - 1)))
    else $error("scroll did not park cursor on last row");

endmodule

bind text_console_char_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

/* bench/tb.sv */
// Testbench for the text console character writer: directed and random command traffic.
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int         CELL_COUNT     = TCW_COLUMNS * TCW_ROWS;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         MAX_REPORTS    = 10;
  localparam int         PHASE_COUNT    = 5;
  localparam int         PHASE_ITEMS    = 258;

  typedef struct packed {
    logic [10:0] offset;
    logic [6:0]  col;
    logic [4:0]  row;
    logic        scrolled;
    logic [15:0] read_word;
  } cursor_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic [10:0] out_cursor_offset;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic        out_scrolled;
  logic [15:0] out_read_cell;

  // Console model: store, cursor and attribute register
  logic [15:0] screen_cells [CELL_COUNT];
  int          cur_col;
  int          cur_row;
  logic [7:0]  attr_shadow;

  cursor_report_t pending_reports [$];
  int             mismatch_count;
  int             idle_cycles;
  bit             gaps_enabled;

  text_console_char_writer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .out_valid         (out_valid),
    .out_cursor_offset (out_cursor_offset),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_scrolled      (out_scrolled),
    .out_read_cell     (out_read_cell)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_cells[i] = {attr_shadow, BLANK_CODE};
    end
  endfunction

  function automatic cursor_report_t console_step(logic [1:0] mode, logic [7:0] code,
                                                  logic [10:0] idx);
    cursor_report_t rpt;
    int             pos;
    logic           did_scroll;
    logic [15:0]    cell_value;
    did_scroll = 1'b0;
    cell_value = '0;
    case (mode)
      MODE_PUT: begin
        case (code)
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          CH_CR: cur_col = 0;
          CH_BS: begin
            if (cur_col > 0) cur_col--;
          end
          CH_TAB: cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
          default: begin
            pos = cur_row * TCW_COLUMNS + cur_col;
            if (pos < CELL_COUNT) screen_cells[pos] = {attr_shadow, code};
            cur_col++;
          end
        endcase
        if (cur_col >= TCW_COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= TCW_ROWS) begin
          // shift every row up one, then blank the bottom row
          for (int i = 0; i < TCW_COLUMNS * (TCW_ROWS - 1); i++) begin
            screen_cells[i] = screen_cells[i + TCW_COLUMNS];
          end
          for (int i = TCW_COLUMNS * (TCW_ROWS - 1); i < CELL_COUNT; i++) begin
            screen_cells[i] = {attr_shadow, BLANK_CODE};
          end
          cur_row    = TCW_ROWS - 1;
          did_scroll = 1'b1;
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      MODE_READ: begin
        if (idx < CELL_COUNT) cell_value = screen_cells[idx];
      end
      default: ;
    endcase
    pos           = cur_row * TCW_COLUMNS + cur_col;
    rpt.offset    = pos[10:0];
    rpt.col       = cur_col[6:0];
    rpt.row       = cur_row[4:0];
    rpt.scrolled  = did_scroll;
    rpt.read_word = cell_value;
    return rpt;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Result checker: every strobed beat is matched against the oldest prediction
  always @(posedge clk) begin
    cursor_report_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat: offset %0d col %0d row %0d",
                                out_cursor_offset, out_cursor_col, out_cursor_row));
      end else begin
        want = pending_reports.pop_front();
        if (out_cursor_offset !== want.offset || out_cursor_col !== want.col ||
            out_cursor_row !== want.row || out_scrolled !== want.scrolled ||
            out_read_cell !== want.read_word) begin
          note_mismatch($sformatf(
            {"result mismatch: exp off %0d col %0d row %0d scr %0b cell %h,",
             " got off %0d col %0d row %0d scr %0b cell %h"},
            want.offset, want.col, want.row, want.scrolled, want.read_word,
            out_cursor_offset, out_cursor_col, out_cursor_row, out_scrolled,
            out_read_cell));
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((start && !busy) || (rst_n && out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_command(input logic [1:0] mode, input logic [7:0] code,
                              input logic [10:0] idx);
    cursor_report_t rpt;
    @(negedge clk);
    start         <= 1'b1;
    in_mode       <= mode;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    rpt = console_step(mode, code, idx);
    pending_reports.push_back(rpt);
  endtask

  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (!gaps_enabled || pick < 65) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else if (pick < 98) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every prediction has been answered
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    attr_shadow = value;
  endtask

  task automatic test_reset_contents();
    send_command(MODE_READ, 8'h00, 11'd0);
    send_command(MODE_READ, 8'hFF, 11'(CELL_COUNT - 1));
    send_command(MODE_READ, 8'h00, 11'h7FF);
    send_command(MODE_UNUSED, 8'h55, 11'h2AA);
  endtask

  task automatic test_control_bytes();
    send_command(MODE_PUT, CH_BS, 11'd0);   // backspace at column 0 stays put
    send_command(MODE_PUT, 8'h00, 11'h7FF);
    send_command(MODE_PUT, 8'hFF, 11'd0);
    send_command(MODE_PUT, 8'h80, 11'd0);
    send_command(MODE_PUT, 8'h7F, 11'd0);
    send_command(MODE_PUT, CH_BS, 11'd0);
    send_command(MODE_PUT, CH_TAB, 11'd0);
    send_command(MODE_PUT, CH_CR, 11'd0);
    send_command(MODE_PUT, CH_LF, 11'd0);
    for (int i = 0; i < 4; i++) begin
      send_command(MODE_READ, 8'h00, 11'(i));
    end
  endtask

  task automatic test_attribute_extremes();
    drain_results();
    write_attribute(8'hFF);
    send_command(MODE_CLEAR, 8'h00, 11'd0);
    send_command(MODE_PUT, 8'h5A, 11'd0);
    send_command(MODE_READ, 8'h00, 11'd0);
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT - 1));
    drain_results();
    write_attribute(8'h00);
    send_command(MODE_PUT, 8'h41, 11'd0);
    send_command(MODE_READ, 8'h00, 11'd1);
  endtask

  task automatic test_scroll();
    send_command(MODE_CLEAR, 8'h00, 11'd0);
    for (int i = 0; i < TCW_ROWS - 1; i++) begin
      send_command(MODE_PUT, CH_LF, 11'd0);
    end
    send_command(MODE_PUT, 8'h41, 11'd0);
    // line feed on the bottom row scrolls
    send_command(MODE_PUT, CH_LF, 11'd0);
    send_command(MODE_PUT, 8'h42, 11'd0);
    // tab off the end of the bottom row scrolls again
    for (int i = 0; i < TCW_COLUMNS / TAB_STOP; i++) begin
      send_command(MODE_PUT, CH_TAB, 11'd0);
    end
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT - 3 * TCW_COLUMNS));
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT - 2 * TCW_COLUMNS));
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT - 1));
  endtask

  task automatic test_random_traffic();
    int         pick;
    int         sub;
    int         pos;
    logic [7:0] phase_attr;
    logic [7:0] code;
    logic [10:0] idx;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      case (ph)
        0: phase_attr = 8'h00;
        1: phase_attr = 8'hFF;
        4: phase_attr = ATTR_RESET;
        default: phase_attr = 8'($urandom_range(0, 255));
      endcase
      write_attribute(phase_attr);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) gaps_enabled = ($urandom_range(0, 9) >= 3);
        pick = $urandom_range(0, 999);
        code = 8'($urandom_range(0, 255));
        idx  = 11'($urandom_range(0, 2047));
        if (pick < 8) begin
          send_command(MODE_CLEAR, code, idx);
        end else if (pick < 25) begin
          send_command(MODE_UNUSED, code, idx);
        end else if (pick < 230) begin
          // favor the cell just written, sometimes past the end of the store
          sub = $urandom_range(0, 99);
          pos = cur_row * TCW_COLUMNS + cur_col;
          if (sub < 40 && pos > 0) idx = 11'(pos - 1);
          else if (sub < 85) idx = 11'($urandom_range(0, CELL_COUNT - 1));
          else idx = 11'($urandom_range(CELL_COUNT, 2047));
          send_command(MODE_READ, code, idx);
        end else begin
          sub = $urandom_range(0, 99);
          if (sub < 9) code = CH_LF;
          else if (sub < 12) code = CH_CR;
          else if (sub < 17) code = CH_BS;
          else if (sub < 24) code = CH_TAB;
          send_command(MODE_PUT, code, idx);
        end
        idle_gap();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    start          = 1'b0;
    in_mode        = MODE_PUT;
    in_char_code   = '0;
    in_cell_index  = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    gaps_enabled   = 1'b1;
    attr_shadow    = ATTR_RESET;
    cur_col        = 0;
    cur_row        = 0;
    blank_screen();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_control_bytes();
    test_attribute_extremes();
    test_scroll();
    test_random_traffic();

    drain_results();
    repeat (20) @(negedge clk);
    if (pending_reports.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tcw_pkg.sv
hdl/tcw_cursor.sv
hdl/text_console_char_writer.sv
hdl/tcw_checker.sv
bench/tb.sv
